FILE: rtl/mbps_pkg.sv
// Shared constants and register index codes for the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

  localparam int MBPS_MAX_PATTERN   = 24;
  localparam int MBPS_POSITION_BITS = 32;

  localparam int PAT_WORD_W  = 64;
  localparam int CARE_W      = 24;
  localparam int LEN_CFG_W   = 5;
  localparam int COUNT_W     = 16;
  localparam int ADDR_W      = 48;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_MID    = 3'd1,
    REG_PAT_HIGH   = 3'd2,
    REG_CARE_MASK  = 3'd3,
    REG_PAT_LENGTH = 3'd4,
    REG_WANTED_OCC = 3'd5,
    REG_BASE_ADDR  = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/masked_byte_pattern_scanner_core.sv
// Top level of the masked byte pattern scanner: window, compare, counters and result register.
//
// The core takes one region byte per cycle while in_stall is low and keeps the last
// MAX_PATTERN bytes in a shift window. Each byte passes through an input register; from
// there the whole window is compared against the pattern in parallel (care-masked), the
// match counter and byte position advance, and a result, if any, is loaded into the
// output register. Throughput is one word per clock when nothing stalls. The pace is
// set by the combinational window compare and the output register: while a result
// waits under out_stall, one more word is held in the input register, and words that
// produce no result keep flowing. A found result carries region_base plus the start
// offset; a region that ends without the wanted occurrence gives one not-found result
// with address 0. After the report, the rest of the region is dropped silently.
// Configuration must be written only while idle; the block does not enforce this.
`default_nettype none

module masked_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN   = mbps_pkg::MBPS_MAX_PATTERN,
  parameter int POSITION_BITS = mbps_pkg::MBPS_POSITION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_end_of_region,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_found,
  output logic [mbps_pkg::ADDR_W-1:0]          out_match_address
);

  import mbps_pkg::*;

  localparam int LEN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN + 1) : 1;
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [3*PAT_WORD_W-1:0] pat_all_r;
  logic [CARE_W-1:0]       care_r;
  logic [LEN_CFG_W-1:0]    len_cfg_r;
  logic [COUNT_W-1:0]      wanted_r;
  logic [ADDR_W-1:0]       base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_all_r <= '0;
      care_r    <= '0;
      len_cfg_r <= LEN_CFG_W'(1);
      wanted_r  <= COUNT_W'(1);
      base_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LOW:    pat_all_r[0 +: PAT_WORD_W] <= cfg_wdata[PAT_WORD_W-1:0];
        REG_PAT_MID:    pat_all_r[PAT_WORD_W +: PAT_WORD_W] <= cfg_wdata[PAT_WORD_W-1:0];
        REG_PAT_HIGH:   pat_all_r[2*PAT_WORD_W +: PAT_WORD_W] <= cfg_wdata[PAT_WORD_W-1:0];
        REG_CARE_MASK:  care_r    <= cfg_wdata[CARE_W-1:0];
        REG_PAT_LENGTH: len_cfg_r <= cfg_wdata[LEN_CFG_W-1:0];
        REG_WANTED_OCC: wanted_r  <= cfg_wdata[COUNT_W-1:0];
        REG_BASE_ADDR:  base_r    <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp pattern length into 1..MAX_PATTERN
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(len_cfg_r) > MAX_PATTERN) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(len_cfg_r);
    end
  end

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // scan state
  logic [7:0]               win_r [MAX_PATTERN];
  logic [POSITION_BITS-1:0] pos_r;
  logic [COUNT_W-1:0]       cnt_r;
  logic                     done_r;

  // output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_addr_r;

  // window as it stands after this word shifts in
  logic [7:0] win_nxt [MAX_PATTERN];
  always_comb begin
    win_nxt[0] = s1_byte_r;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // pattern byte j lines up with window entry len-1-j
  logic             all_ok;
  logic [IDX_W-1:0] sel;
  always_comb begin
    all_ok = 1'b1;
    sel    = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      sel = IDX_W'(int'(len_eff) - 1 - j);
      if ((j < int'(len_eff)) && care_r[j] && (win_nxt[sel] != pat_all_r[8*j +: 8])) begin
        all_ok = 1'b0;
      end
    end
  end

  logic                     shift_en;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [COUNT_W-1:0]       cnt_inc;
  logic                     hit;
  logic                     found_now;
  logic                     has_res;
  logic                     out_free;
  logic                     proceed;
  logic [POSITION_BITS-1:0] start_off;
  logic [ADDR_W-1:0]        match_addr;

  always_comb begin
    shift_en   = !done_r && (pos_r != POS_MAX);
    pos_inc    = pos_r + POSITION_BITS'(1);
    cnt_inc    = (cnt_r != COUNT_MAX) ? cnt_r + COUNT_W'(1) : cnt_r;
    hit        = shift_en && (pos_inc >= POSITION_BITS'(len_eff)) && all_ok;
    found_now  = hit && (cnt_inc == wanted_r);
    has_res    = found_now || (s1_last_r && !done_r);
    out_free   = !out_valid_r || !out_stall;
    proceed    = s1_valid_r && (out_free || !has_res);
    start_off  = pos_inc - POSITION_BITS'(len_eff);
    match_addr = base_r + ADDR_W'(start_off);
  end

  assign in_stall = s1_valid_r && !proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // input register: load on accept, drop once processed
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (proceed) begin
        s1_valid_r <= 1'b0;
      end

      if (proceed) begin
        if (s1_last_r) begin
          pos_r  <= '0;
          cnt_r  <= '0;
          done_r <= 1'b0;
        end else begin
          if (shift_en) begin
            pos_r <= pos_inc;
          end
          if (hit) begin
            cnt_r <= cnt_inc;
          end
          if (found_now) begin
            done_r <= 1'b1;
          end
        end
      end

      if (out_free) begin
        out_valid_r <= proceed && has_res;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_end_of_region;
    end
    if (proceed && shift_en) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
    if (out_free) begin
      out_found_r <= found_now;
      out_addr_r  <= found_now ? match_addr : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

`default_nettype wire

FILE: rtl/mbps_checker.sv
// Port-level checker for the masked byte pattern scanner, bound to the top level.
`default_nettype none

module mbps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_found,
  input wire logic [47:0] out_match_address
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_match_address))
    else $error("result word changed while stalled");

  // not-found results carry a zero address
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == 48'd0)
    else $error("not-found result with nonzero address");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_mbps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_found         (out_found),
  .out_match_address (out_match_address)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking bench for the masked byte pattern scanner core.
`timescale 1ns / 100ps

module tb_top;
  import mbps_pkg::*;

  localparam int MAX_PAT    = MBPS_MAX_PATTERN;
  localparam int DRAIN_GAP  = 6;
  localparam int LONG_HOLD  = 300;
  localparam int LIMIT      = 1000000;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } region_byte_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  typedef struct {
    logic [63:0]       lo;
    logic [63:0]       mid;
    logic [63:0]       hi;
    logic [CARE_W-1:0] care;
    logic [4:0]        len;
    logic [15:0]       want;
    logic [ADDR_W-1:0] base;
  } scan_cfg_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  cfg_reg_t               cfg_index = REG_PAT_LOW;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_data_byte = 8'h00;
  logic                   in_end_of_region = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_found;
  logic [ADDR_W-1:0]      out_match_address;

  masked_byte_pattern_scanner_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_region  (in_end_of_region),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scanner mirror: configuration and per-region state
  scan_cfg_t    m_cfg;
  logic [7:0]   win [MAX_PAT];
  logic [31:0]  scan_pos = '0;
  logic [15:0]  hit_cnt = '0;
  logic         scan_done = 1'b0;

  region_byte_t byte_q [$];
  scan_result_t scan_result_q [$];
  region_byte_t drv_item;
  scan_result_t want_r;

  int  queued_cnt = 0;
  int  bytes_taken = 0;
  int  regions_taken = 0;
  int  found_cnt = 0;
  int  miss_cnt = 0;
  int  fail_cnt = 0;
  int  settings_cnt = 0;
  int  idle_pct = 19;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;
  int  cycle_cnt = 0;
  bit  src_hold = 1'b0;

  function automatic int eff_len();
    if (m_cfg.len == 0) return 1;
    if (m_cfg.len > MAX_PAT) return MAX_PAT;
    return int'(m_cfg.len);
  endfunction

  function automatic void restart_region();
    scan_pos  = '0;
    hit_cnt   = '0;
    scan_done = 1'b0;
  endfunction

  // advance the mirror by one accepted byte and queue the result it causes
  function automatic void scan_step(input logic [7:0] b, input logic last);
    int           len;
    logic         hit;
    logic         reported;
    logic [191:0] pat;
    scan_result_t r;
    len = eff_len();
    reported = 1'b0;
    if (scan_done) begin
      if (last) restart_region();
      return;
    end
    if (scan_pos != '1) begin
      for (int k = MAX_PAT - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = b;
      scan_pos = scan_pos + 32'd1;
      if (scan_pos >= 32'(len)) begin
        pat = {m_cfg.hi, m_cfg.mid, m_cfg.lo};
        hit = 1'b1;
        for (int j = 0; j < len; j++) begin
          if (m_cfg.care[j] && win[len-1-j] != pat[j*8 +: 8]) hit = 1'b0;
        end
        if (hit) begin
          if (hit_cnt != 16'hFFFF) hit_cnt = hit_cnt + 16'd1;
          if (hit_cnt == m_cfg.want) begin
            r.found = 1'b1;
            r.addr  = m_cfg.base + ADDR_W'(scan_pos - 32'(len));
            scan_result_q.push_back(r);
            reported  = 1'b1;
            scan_done = 1'b1;
          end
        end
      end
    end
    if (last) begin
      if (!reported) begin
        r.found = 1'b0;
        r.addr  = '0;
        scan_result_q.push_back(r);
      end
      restart_region();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    if (fail_cnt < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_cnt, what, exp_v, got_v);
    fail_cnt++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    logic [63:0] keep;
    keep = '1;
    case (idx)
      REG_PAT_LOW:    m_cfg.lo = val;
      REG_PAT_MID:    m_cfg.mid = val;
      REG_PAT_HIGH:   m_cfg.hi = val;
      REG_CARE_MASK: begin
        m_cfg.care = val[CARE_W-1:0];
        keep = 64'hFF_FFFF;
      end
      REG_PAT_LENGTH: begin
        m_cfg.len = val[4:0];
        keep = 64'h1F;
      end
      REG_WANTED_OCC: begin
        m_cfg.want = val[15:0];
        keep = 64'hFFFF;
      end
      REG_BASE_ADDR: begin
        m_cfg.base = val[ADDR_W-1:0];
        keep = 64'hFFFF_FFFF_FFFF;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    // junk above the register width must be dropped by the block
    cfg_wdata <= (val & keep) | ({$urandom, $urandom} & ~keep);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input scan_cfg_t c);
    write_reg(REG_PAT_LOW, c.lo);
    write_reg(REG_PAT_MID, c.mid);
    write_reg(REG_PAT_HIGH, c.hi);
    write_reg(REG_CARE_MASK, 64'(c.care));
    write_reg(REG_PAT_LENGTH, 64'(c.len));
    write_reg(REG_WANTED_OCC, 64'(c.want));
    write_reg(REG_BASE_ADDR, 64'(c.base));
    settings_cnt++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    region_byte_t w;
    w.data = b;
    w.last = last;
    byte_q.push_back(w);
    queued_cnt++;
  endtask

  // first byte of the region in the most significant used byte
  task automatic queue_packed(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) queue_byte(v[i*8 +: 8], i == 0);
  endtask

  task automatic queue_random_region();
    logic [7:0]   rb [$];
    logic [191:0] pat;
    int           len;
    int           goal;
    int           r;
    int           j;
    int           k;
    len = eff_len();
    pat = {m_cfg.hi, m_cfg.mid, m_cfg.lo};
    goal = $urandom_range(3 * len + 6, 1);
    if ($urandom_range(9) == 0) goal = 1;
    while (rb.size() < goal) begin
      r = $urandom_range(9);
      if (r < 5) begin
        k = rb.size();
        for (j = 0; j < len; j++) rb.push_back(m_cfg.care[j] ? pat[j*8 +: 8] : 8'($urandom));
        // break a cared byte now and then
        if (r == 4) begin
          j = $urandom_range(len - 1);
          if (m_cfg.care[j]) rb[k+j] = rb[k+j] ^ 8'($urandom_range(255, 1));
        end
      end else if (r == 5) begin
        rb.push_back(pat[7:0]);
      end else begin
        rb.push_back(8'($urandom));
      end
    end
    for (j = 0; j < rb.size(); j++) queue_byte(rb[j], j == rb.size() - 1);
  endtask

  function automatic scan_cfg_t random_cfg();
    scan_cfg_t c;
    int        r;
    c.lo  = {$urandom, $urandom};
    c.mid = {$urandom, $urandom};
    c.hi  = {$urandom, $urandom};
    r = $urandom_range(9);
    c.care = (r == 0) ? 24'h0 : (r == 1) ? 24'hFF_FFFF : 24'($urandom);
    r = $urandom_range(9);
    if (r < 7) c.len = 5'($urandom_range(6, 1));
    else if (r < 9) c.len = 5'($urandom_range(24, 7));
    else c.len = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 25));
    r = $urandom_range(19);
    if (r < 12) c.want = 16'd1;
    else if (r < 17) c.want = 16'($urandom_range(4, 2));
    else if (r < 19) c.want = 16'd0;
    else c.want = 16'($urandom);
    c.base = ($urandom_range(7) == 0) ? '1 : ADDR_W'({$urandom, $urandom});
    return c;
  endfunction

  // wait until every queued word is taken and every result is back
  task automatic drain();
    while (bytes_taken != queued_cnt || scan_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_step(in_data_byte, in_end_of_region);
        bytes_taken++;
        if (in_end_of_region) regions_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && !src_hold && $urandom_range(99) >= idle_pct) begin
          drv_item = byte_q.pop_front();
          in_valid         <= 1'b1;
          in_data_byte     <= drv_item.data;
          in_end_of_region <= drv_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scan_result_q.size() == 0) begin
          report_mismatch("result with none pending, found", 64'h0, 64'(out_found));
        end else begin
          want_r = scan_result_q.pop_front();
          if (out_found !== want_r.found)
            report_mismatch("found", 64'(want_r.found), 64'(out_found));
          if (out_match_address !== want_r.addr)
            report_mismatch("match_address", 64'(want_r.addr), 64'(out_match_address));
          if (want_r.found) found_cnt++;
          else miss_cnt++;
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    scan_cfg_t c;
    int        ph;
    int        goal;
    m_cfg.lo   = '0;
    m_cfg.mid  = '0;
    m_cfg.hi   = '0;
    m_cfg.care = '0;
    m_cfg.len  = 5'd1;
    m_cfg.want = 16'd1;
    m_cfg.base = '0;
    for (int k = 0; k < MAX_PAT; k++) win[k] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: de ad be ef, all cared, base at the top of the address space
    c.lo = 64'h0000_0000_EFBE_ADDE;
    c.mid = '0;
    c.hi = '0;
    c.care = 24'h00_000F;
    c.len = 5'd4;
    c.want = 16'd1;
    c.base = '1;
    set_config(c);
    queue_packed(64'h00DE_ADBE_EF11, 6);
    queue_packed(64'hDEAD_BEEF, 4);      // hit on the closing byte
    queue_packed(64'hDEAD, 2);           // shorter than the pattern
    queue_packed(64'hDEAD_BEEF_FFFF, 6); // tail after the report is dropped
    queue_packed(64'hFF, 1);
    drain();

    // length zero acts as one, all wildcards, occurrence zero never reports a match
    c.lo = '1;
    c.mid = '1;
    c.hi = '1;
    c.care = '0;
    c.len = 5'd0;
    c.want = 16'd0;
    c.base = '0;
    set_config(c);
    queue_packed(64'h00FF, 2);
    drain();

    for (ph = 0; ph < 12; ph++) begin
      c = random_cfg();
      if (ph == 0) begin
        c.care = '1;
        c.len = 5'd31;
        c.want = 16'd2;
        c.base = '1;
      end
      idle_pct = (ph == 5) ? 0 : 19;
      set_config(c);
      goal = queued_cnt + 110;
      while (queued_cnt < goal) queue_random_region();
      if (ph == 3) begin
        while (bytes_taken + 60 < queued_cnt) @(posedge clk);
        src_hold = 1'b1;
        @(posedge clk);
        while (in_valid || scan_result_q.size() != 0) @(posedge clk);
        src_hold = 1'b0;
      end
      drain();
    end

    // every byte ends a region, so results pile up behind a long output hold
    idle_pct = 19;
    c.lo = 64'h5A;
    c.care = 24'h1;
    c.len = 5'd1;
    c.want = 16'd1;
    c.base = ADDR_W'({$urandom, $urandom});
    set_config(c);
    hold_req++;
    repeat (80) queue_byte($urandom_range(1) ? 8'h5A : 8'($urandom), 1'b1);
    drain();

    $display("covered %0d bytes in %0d regions over %0d register settings",
             bytes_taken, regions_taken, settings_cnt);
    $display("results: %0d found, %0d not found, %0d mismatches", found_cnt, miss_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
